/* hw/rtl/rmonpsc_pkg.sv */
// Package for the per-port statistics counter block.
// Sizes, codes, the queued operation type and the size-bin lookup.
// No dependencies.
`default_nettype none
package rmonpsc_pkg;

  localparam int NUM_PORTS     = 16;
  localparam int COUNTER_WIDTH = 64;
  localparam int NUM_BINS      = 13;
  localparam int NUM_BASIC     = 4;
  localparam int QUEUE_DEPTH   = 2;

  localparam int PORT_W     = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
  localparam int BIN_ENTRIES = NUM_PORTS * NUM_BINS;
  localparam int BIN_ADDR_W = $clog2(BIN_ENTRIES);
  localparam int BIN_W      = $clog2(NUM_BINS);
  localparam int ROW_W      = NUM_BASIC * COUNTER_WIDTH;

  localparam int LEN_64    = 64;
  localparam int LEN_128   = 128;
  localparam int LEN_256   = 256;
  localparam int LEN_512   = 512;
  localparam int LEN_1024  = 1024;
  localparam int LEN_1519  = 1519;
  localparam int LEN_2048  = 2048;
  localparam int LEN_4096  = 4096;
  localparam int LEN_8192  = 8192;
  localparam int LEN_9019  = 9019;
  localparam int LEN_10240 = 10240;

  localparam logic CMD_COUNT = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  localparam logic CFG_STATS_ENABLE = 1'b0;
  localparam logic CFG_PORT_BASE    = 1'b1;

  localparam logic [4:0] IDX_PKTS    = 5'd0;
  localparam logic [4:0] IDX_BYTES   = 5'd1;
  localparam logic [4:0] IDX_BCAST   = 5'd2;
  localparam logic [4:0] IDX_MCAST   = 5'd3;
  localparam logic [4:0] IDX_BIN_LO  = 5'd4;
  localparam logic [4:0] IDX_BIN_HI  = 5'd16;

  typedef enum logic [2:0] {
    SEL_PKTS  = 3'd0,
    SEL_BYTES = 3'd1,
    SEL_BCAST = 3'd2,
    SEL_MCAST = 3'd3,
    SEL_BIN   = 3'd4,
    SEL_NONE  = 3'd5
  } sel_t;

  typedef struct packed {
    logic                  is_read;
    logic                  port_ok;
    logic [PORT_W-1:0]     lp;
    sel_t                  sel;
    logic [BIN_ADDR_W-1:0] bin_addr;
    logic [15:0]           cap_len;
    logic                  is_bcast;
    logic                  is_mcast;
  } op_t;

  function automatic logic [BIN_W-1:0] size_bin(input logic [15:0] len);
    logic [BIN_W-1:0] b;
    if (len < 16'(LEN_64))         b = BIN_W'(0);
    else if (len == 16'(LEN_64))   b = BIN_W'(1);
    else if (len < 16'(LEN_128))   b = BIN_W'(2);
    else if (len < 16'(LEN_256))   b = BIN_W'(3);
    else if (len < 16'(LEN_512))   b = BIN_W'(4);
    else if (len < 16'(LEN_1024))  b = BIN_W'(5);
    else if (len < 16'(LEN_1519))  b = BIN_W'(6);
    else if (len < 16'(LEN_2048))  b = BIN_W'(7);
    else if (len < 16'(LEN_4096))  b = BIN_W'(8);
    else if (len < 16'(LEN_8192))  b = BIN_W'(9);
    else if (len < 16'(LEN_9019))  b = BIN_W'(10);
    else if (len < 16'(LEN_10240)) b = BIN_W'(11);
    else                           b = BIN_W'(12);
    return b;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/rmonpsc_if.sv */
// Channel interfaces: request, response and configuration write.
// Depends on rmonpsc_pkg for nothing but keeps the same naming.
`default_nettype none
interface rmonpsc_req_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [7:0]  port;
  logic [15:0] wire_len;
  logic [15:0] cap_len;
  logic [47:0] dest_mac;
  logic [4:0]  counter_index;
  modport source (output valid, command, port, wire_len, cap_len, dest_mac, counter_index,
                  input ready);
  modport sink (input valid, command, port, wire_len, cap_len, dest_mac, counter_index,
                output ready);
endinterface

interface rmonpsc_rsp_if;
  logic        valid;
  logic        ready;
  logic [63:0] read_data;
  logic        port_invalid;
  modport source (output valid, read_data, port_invalid, input ready);
  modport sink (input valid, read_data, port_invalid, output ready);
endinterface

interface rmonpsc_cfg_if;
  logic       valid;
  logic       ready;
  logic       index;
  logic [7:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* hw/rtl/rmonpsc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module rmonpsc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* hw/rtl/rmonpsc_front.sv */
// Front end: holds configuration, accepts requests and classifies them.
// Depends on rmonpsc_pkg and the channel interfaces.
`default_nettype none
module rmonpsc_front
  import rmonpsc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  rmonpsc_req_if.sink     req,
  rmonpsc_cfg_if.sink     cfg,
  output op_t             push_op,
  output logic            push_valid,
  input  wire logic       push_ready
);

  logic       stats_enable;
  logic [7:0] port_base;
  logic [7:0] diff;
  logic       port_ok;
  logic [BIN_W-1:0] bin;
  logic       drop;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      stats_enable <= 1'b1;
      port_base    <= 8'd0;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_STATS_ENABLE: stats_enable <= cfg.data[0];
        CFG_PORT_BASE:    port_base    <= cfg.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    diff    = req.port - port_base;
    port_ok = (req.port >= port_base) && ({1'b0, diff} < 9'(NUM_PORTS));

    push_op          = '0;
    push_op.is_read  = (req.command == CMD_READ);
    push_op.port_ok  = port_ok;
    push_op.lp       = diff[PORT_W-1:0];
    push_op.cap_len  = req.cap_len;
    push_op.is_bcast = (req.dest_mac == 48'hFFFF_FFFF_FFFF);
    push_op.is_mcast = req.dest_mac[40] && !push_op.is_bcast;
    push_op.sel      = SEL_NONE;
    bin              = size_bin(req.wire_len);

    if (push_op.is_read) begin
      case (req.counter_index) inside
        IDX_PKTS:                 push_op.sel = SEL_PKTS;
        IDX_BYTES:                push_op.sel = SEL_BYTES;
        IDX_BCAST:                push_op.sel = SEL_BCAST;
        IDX_MCAST:                push_op.sel = SEL_MCAST;
        [IDX_BIN_LO:IDX_BIN_HI]:  push_op.sel = SEL_BIN;
        default:                  push_op.sel = SEL_NONE;
      endcase
      bin = BIN_W'(req.counter_index - IDX_BIN_LO);
    end

    push_op.bin_addr = BIN_ADDR_W'(push_op.lp) * BIN_ADDR_W'(NUM_BINS) + BIN_ADDR_W'(bin);

    drop       = !push_op.is_read && (!port_ok || !stats_enable);
    req.ready  = push_ready;
    push_valid = req.valid && !drop;
  end

endmodule
`default_nettype wire

/* hw/rtl/rmonpsc_queue.sv */
// Short operation queue between front end and counter engine.
// Depends on rmonpsc_pkg.
`default_nettype none
module rmonpsc_queue
  import rmonpsc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  op_t       push_op,
  input  wire logic push_valid,
  output logic      push_ready,
  output op_t       pop_op,
  output logic      pop_valid,
  input  wire logic pop_ready
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  op_t             slots [QUEUE_DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [AW:0]     count;
  logic            do_push;
  logic            do_pop;

  assign push_ready = (count != (AW + 1)'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_op     = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      count <= count + (AW + 1)'(do_push) - (AW + 1)'(do_pop);
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/rmonpsc_back.sv */
// Counter engine: read-modify-write of counter RAMs and read responses.
// Depends on rmonpsc_pkg, rmonpsc_ram and the response interface.
`default_nettype none
module rmonpsc_back
  import rmonpsc_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  op_t         pop_op,
  input  wire logic   pop_valid,
  output logic        pop_ready,
  rmonpsc_rsp_if.source rsp
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t state;
  state_t state_next;
  op_t    op;

  logic [NUM_PORTS-1:0]   row_vld;
  logic [BIN_ENTRIES-1:0] bin_vld;

  logic [ROW_W-1:0]         row_q;
  logic [ROW_W-1:0]         row_wdata;
  logic [COUNTER_WIDTH-1:0] bin_q;
  logic [COUNTER_WIDTH-1:0] bin_wdata;
  logic                     we;
  logic [PORT_W-1:0]        row_raddr;
  logic [BIN_ADDR_W-1:0]    bin_raddr;

  logic [COUNTER_WIDTH-1:0] c_pkts, c_bytes, c_bcast, c_mcast, c_bin;
  logic [COUNTER_WIDTH-1:0] sel_val;
  logic                     rsp_load;
  logic                     rsp_free;

  logic        rsp_valid;
  logic [63:0] read_data;
  logic        port_invalid;

  assign rsp.valid        = rsp_valid;
  assign rsp.read_data    = read_data;
  assign rsp.port_invalid = port_invalid;

  assign pop_ready = (state == ST_IDLE);
  assign row_raddr = (state == ST_IDLE) ? pop_op.lp : op.lp;
  assign bin_raddr = (state == ST_IDLE) ? pop_op.bin_addr : op.bin_addr;

  rmonpsc_ram #(.WIDTH(ROW_W), .DEPTH(NUM_PORTS)) u_row_ram (
    .clk   (clk),
    .we    (we),
    .waddr (op.lp),
    .wdata (row_wdata),
    .raddr (row_raddr),
    .rdata (row_q)
  );

  rmonpsc_ram #(.WIDTH(COUNTER_WIDTH), .DEPTH(BIN_ENTRIES)) u_bin_ram (
    .clk   (clk),
    .we    (we),
    .waddr (op.bin_addr),
    .wdata (bin_wdata),
    .raddr (bin_raddr),
    .rdata (bin_q)
  );

  always_comb begin
    if (row_vld[op.lp]) begin
      c_pkts  = row_q[0*COUNTER_WIDTH +: COUNTER_WIDTH];
      c_bytes = row_q[1*COUNTER_WIDTH +: COUNTER_WIDTH];
      c_bcast = row_q[2*COUNTER_WIDTH +: COUNTER_WIDTH];
      c_mcast = row_q[3*COUNTER_WIDTH +: COUNTER_WIDTH];
    end else begin
      c_pkts  = '0;
      c_bytes = '0;
      c_bcast = '0;
      c_mcast = '0;
    end
    c_bin = bin_vld[op.bin_addr] ? bin_q : '0;

    row_wdata = {c_mcast + COUNTER_WIDTH'(op.is_mcast),
                 c_bcast + COUNTER_WIDTH'(op.is_bcast),
                 c_bytes + COUNTER_WIDTH'(op.cap_len),
                 c_pkts + COUNTER_WIDTH'(1)};
    bin_wdata = c_bin + COUNTER_WIDTH'(1);

    case (op.sel)
      SEL_PKTS:  sel_val = c_pkts;
      SEL_BYTES: sel_val = c_bytes;
      SEL_BCAST: sel_val = c_bcast;
      SEL_MCAST: sel_val = c_mcast;
      SEL_BIN:   sel_val = c_bin;
      default:   sel_val = '0;
    endcase
    if (!op.port_ok) begin
      sel_val = '0;
    end

    rsp_free   = !rsp_valid || rsp.ready;
    we         = (state == ST_EXEC) && !op.is_read;
    rsp_load   = (state == ST_EXEC) && op.is_read && rsp_free;
    state_next = state;
    case (state)
      ST_IDLE: if (pop_valid) state_next = ST_EXEC;
      ST_EXEC: if (we || rsp_load) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && pop_valid) begin
      op <= pop_op;
    end
    if (rsp_load) begin
      read_data    <= 64'(sel_val);
      port_invalid <= !op.port_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      row_vld   <= '0;
      bin_vld   <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (we) begin
        row_vld[op.lp]       <= 1'b1;
        bin_vld[op.bin_addr] <= 1'b1;
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/rmon_port_statistics_counters_unit.sv */
// Top level of the per-port RMON statistics counters.
// Depends on rmonpsc_pkg, the channel interfaces, front, queue and back.
//
//   channel  dir  words
//   req      in   count a packet or read one counter
//   rsp      out  one word per read request
//   cfg      in   register writes: 0 stats_enable, 1 port_base
//
// The front end takes one request per cycle while the queue has room.
// The counter engine handles each queued operation in ST_IDLE (RAM read),
// then ST_EXEC (update or respond), and pops the next one only in ST_IDLE.
// Dropped packet words (disabled or port out of range) skip the queue but still wait for room.
// Reset clears per-row and per-entry valid bits; no clearing pass.
// A held response stalls the engine; the queue keeps accepting until it is full.
`default_nettype none
module rmon_port_statistics_counters_unit
  import rmonpsc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  rmonpsc_req_if.sink   req,
  rmonpsc_rsp_if.source rsp,
  rmonpsc_cfg_if.sink   cfg
);

  op_t  push_op;
  logic push_valid;
  logic push_ready;
  op_t  pop_op;
  logic pop_valid;
  logic pop_ready;

  rmonpsc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .cfg        (cfg),
    .push_op    (push_op),
    .push_valid (push_valid),
    .push_ready (push_ready)
  );

  rmonpsc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_op    (push_op),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .pop_op     (pop_op),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready)
  );

  rmonpsc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_op    (pop_op),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .rsp       (rsp)
  );

endmodule
`default_nettype wire
